@@ src/bcj2d_pkg.sv @@
// Shared types and constants of the BCJ2 x86 branch decoder.
package bcj2d_pkg;

  // Probability store
  localparam int unsigned PROB_W     = 11;
  localparam int unsigned PROB_DEPTH = 258;
  localparam int unsigned PROB_AW    = 9;
  localparam logic [PROB_W-1:0] PROB_INIT = 11'h400;

  localparam logic [PROB_AW-1:0] IDX_JCC       = 9'd0;
  localparam logic [PROB_AW-1:0] IDX_JMP       = 9'd1;
  localparam logic [PROB_AW-1:0] IDX_CALL_BASE = 9'd2;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam logic REG_OUTPUT_SIZE = 1'b0;

  // Opcodes
  localparam logic [7:0] OP_CALL = 8'hE8;
  localparam logic [7:0] OP_JMP  = 8'hE9;
  localparam logic [7:0] OP_ESC  = 8'h0F;
  localparam logic [3:0] JCC_HI  = 4'h8;

  localparam logic [2:0] START_LAST = 3'd4;

  // Wanted item codes
  localparam logic [2:0] NEED_MAIN  = 3'd0;
  localparam logic [2:0] NEED_RANGE = 3'd1;
  localparam logic [2:0] NEED_CALL  = 3'd2;
  localparam logic [2:0] NEED_JUMP  = 3'd3;
  localparam logic [2:0] NEED_NONE  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_OVERRUN   = 3'd2;
  localparam logic [2:0] ST_BAD_CODE  = 3'd3;
  localparam logic [2:0] ST_OOT       = 3'd4;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_MAIN  = 7'b0000010,
    PH_BIT   = 7'b0000100,
    PH_ADDR  = 7'b0001000,
    PH_END   = 7'b0010000,
    PH_DONE  = 7'b0100000,
    PH_FAIL  = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    CTX_NONE = 2'd0,
    CTX_CALL = 2'd1,
    CTX_JMP  = 2'd2,
    CTX_JCC  = 2'd3
  } ctx_e;

  // Results of one input transaction
  typedef struct packed {
    logic [31:0] word;
    logic        byte_valid;
    logic        multi;
    logic [2:0]  need;
    logic [2:0]  status;
    logic        finished;
  } rec_t;

  typedef struct packed {
    logic               we;
    logic [PROB_AW-1:0] addr;
    logic [PROB_W-1:0]  data;
  } prob_wr_t;

endpackage

@@ src/bcj2d_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface bcj2d_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  byte_value;
  logic [31:0] address_word;

  modport source (output valid, mode, byte_value, address_word, input ready);
  modport sink (input valid, mode, byte_value, address_word, output ready);
endinterface

interface bcj2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] need;
  logic [2:0] status;
  logic       finished;
  logic       last;

  modport source (output valid, out_byte, byte_valid, need, status, finished, last,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, need, status, finished, last,
                output ready);
endinterface

@@ src/bcj2d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bcj2d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bcj2d_core.sv @@
// Decoder core: coder state, branch sequencing and probability read-modify-write.
module bcj2d_core #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [31:0]                        output_size_i,
  bcj2d_in_if.sink                           in_i,
  input  logic                               pend_full_i,
  output logic                               push_o,
  output bcj2d_pkg::rec_t                    rec_o,
  output bcj2d_pkg::prob_wr_t                prob_wr_o,
  output logic [bcj2d_pkg::PROB_AW-1:0]      prob_raddr_o,
  input  logic [bcj2d_pkg::PROB_W-1:0]       prob_rdata_i
);
  import bcj2d_pkg::*;

  phase_e              phase_q, phase_d;
  ctx_e                ctx_q, ctx_d;
  logic [2:0]          start_q, start_d;
  logic [31:0]         range_q, range_d;
  logic [31:0]         code_q, code_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [7:0]          prev_q, prev_d;
  logic                dec_q, dec_d;
  logic                dec_bv_q, dec_bv_d;
  logic [PROB_AW-1:0]  idx_q, idx_d;
  logic                clear_q;
  logic [PROB_AW-1:0]  clr_addr_q;

  logic                 in_fire;
  logic [POS_WIDTH-1:0] size_ext;
  logic [31:0]          code_n, range_n, rel, bound;
  logic                 bit_set, overrun, to_main, to_end;
  logic [PROB_W-1:0]    p_inc, p_dec;
  logic [2:0]           status;

  function automatic logic [2:0] want_f(phase_e ph, ctx_e c);
    logic [2:0] w;
    unique case (ph)
      PH_START: w = NEED_RANGE;
      PH_MAIN:  w = NEED_MAIN;
      PH_BIT:   w = NEED_RANGE;
      PH_ADDR:  w = (c == CTX_CALL) ? NEED_CALL : NEED_JUMP;
      PH_END:   w = NEED_RANGE;
      default:  w = NEED_NONE;
    endcase
    return w;
  endfunction

  function automatic logic [PROB_AW-1:0] idx_f(ctx_e c, logic [7:0] prev);
    logic [PROB_AW-1:0] i;
    unique case (c)
      CTX_CALL: i = IDX_CALL_BASE + PROB_AW'(prev);
      CTX_JMP:  i = IDX_JMP;
      default:  i = IDX_JCC;
    endcase
    return i;
  endfunction

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = !clear_q && !dec_q && !pend_full_i;
  assign size_ext = POS_WIDTH'(output_size_i);
  assign code_n   = {code_q[23:0], in_i.byte_value};
  assign range_n  = {range_q[23:0], 8'h00};
  assign rel      = in_i.address_word - 32'(pos_q + POS_WIDTH'(4));

  // Bit decode, in the dec_q stage of a decode transaction
  assign bound   = {11'b0, range_q[31:11]} * {21'b0, prob_rdata_i};
  assign bit_set = !(code_q < bound);
  assign p_inc   = prob_rdata_i + PROB_W'((12'd2048 - {1'b0, prob_rdata_i}) >> 5);
  assign p_dec   = prob_rdata_i - (prob_rdata_i >> 5);
  // fewer than four bytes left before output_size
  assign overrun = ({1'b0, pos_q} + (POS_WIDTH+1)'(4)) > {1'b0, size_ext};

  always_comb begin
    phase_d  = phase_q;
    ctx_d    = ctx_q;
    start_d  = start_q;
    range_d  = range_q;
    code_d   = code_q;
    pos_d    = pos_q;
    prev_d   = prev_q;
    dec_d    = 1'b0;
    dec_bv_d = 1'b0;
    to_main  = 1'b0;
    to_end   = 1'b0;
    status   = ST_OK;
    push_o   = 1'b0;
    rec_o.word       = '0;
    rec_o.byte_valid = 1'b0;
    rec_o.multi      = 1'b0;

    if (dec_q) begin
      push_o = 1'b1;
      // echo of the opcode byte that started this decode, if any
      rec_o.byte_valid = dec_bv_q;
      if (dec_bv_q) rec_o.word = {24'b0, (ctx_q == CTX_CALL) ? OP_CALL : prev_q};
      if (!bit_set) begin
        range_d = bound;
        if (ctx_q == CTX_CALL) prev_d = OP_CALL;
        ctx_d   = CTX_NONE;
        to_main = 1'b1;
      end else begin
        code_d  = code_q - bound;
        range_d = range_q - bound;
        if (overrun) begin
          ctx_d   = CTX_NONE;
          phase_d = PH_FAIL;
          status  = ST_OVERRUN;
        end else begin
          phase_d = PH_ADDR;
        end
      end
    end else if (in_fire) begin
      if ({1'b0, in_i.mode} != want_f(phase_q, ctx_q)) begin
        status = ST_OOT;
      end else begin
        unique case (phase_q)
          PH_START: begin
            code_d = code_n;
            if (start_q == '0 && in_i.byte_value != '0) begin
              range_d = '0;
              code_d  = '0;
              phase_d = PH_FAIL;
              status  = ST_BAD_START;
            end else begin
              start_d = start_q + 3'd1;
              if (start_q == START_LAST) begin
                if (code_n == '1) begin
                  range_d = '0;
                  code_d  = '0;
                  phase_d = PH_FAIL;
                  status  = ST_BAD_START;
                end else begin
                  range_d = '1;
                  to_main = 1'b1;
                end
              end
            end
          end
          PH_MAIN: begin
            rec_o.byte_valid = 1'b1;
            rec_o.word       = {24'b0, in_i.byte_value};
            pos_d = pos_q + POS_WIDTH'(1);
            if (in_i.byte_value == OP_CALL) begin
              ctx_d   = CTX_CALL;
              phase_d = PH_BIT;
            end else if (in_i.byte_value == OP_JMP) begin
              ctx_d   = CTX_JMP;
              prev_d  = in_i.byte_value;
              phase_d = PH_BIT;
            end else if (in_i.byte_value[7:4] == JCC_HI && prev_q == OP_ESC) begin
              ctx_d   = CTX_JCC;
              prev_d  = in_i.byte_value;
              phase_d = PH_BIT;
            end else begin
              prev_d  = in_i.byte_value;
              to_main = 1'b1;
            end
            if (phase_d == PH_BIT) dec_d = (range_q[31:24] != '0);
            dec_bv_d = dec_d;
          end
          PH_BIT: begin
            range_d = range_n;
            code_d  = code_n;
            dec_d   = (range_n[31:24] != '0);
          end
          PH_END: begin
            range_d = range_n;
            code_d  = code_n;
            to_end  = 1'b1;
          end
          PH_ADDR: begin
            rec_o.byte_valid = 1'b1;
            rec_o.multi      = 1'b1;
            rec_o.word       = rel;
            pos_d   = pos_q + POS_WIDTH'(4);
            prev_d  = rel[31:24];
            ctx_d   = CTX_NONE;
            to_main = 1'b1;
          end
          default: ;
        endcase
      end
      push_o = !dec_d;
    end

    // Main-phase size check, then the end check once the coder is normalized
    if (to_main && pos_d < size_ext) begin
      phase_d = PH_MAIN;
    end else if (to_main || to_end) begin
      if (range_d[31:24] == '0) begin
        phase_d = PH_END;
      end else if (code_d != '0) begin
        phase_d = PH_FAIL;
        status  = ST_BAD_CODE;
      end else begin
        phase_d = PH_DONE;
      end
    end

    rec_o.need     = want_f(phase_d, ctx_d);
    rec_o.status   = status;
    rec_o.finished = (phase_d == PH_DONE);
  end

  assign prob_raddr_o = idx_f(ctx_d, prev_d);
  assign idx_d = dec_d ? prob_raddr_o : idx_q;

  assign prob_wr_o.we   = clear_q || dec_q;
  assign prob_wr_o.addr = clear_q ? clr_addr_q : idx_q;
  assign prob_wr_o.data = clear_q ? PROB_INIT : (bit_set ? p_dec : p_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      ctx_q      <= CTX_NONE;
      start_q    <= '0;
      range_q    <= '0;
      code_q     <= '0;
      pos_q      <= '0;
      prev_q     <= '0;
      dec_q      <= 1'b0;
      dec_bv_q   <= 1'b0;
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      phase_q  <= phase_d;
      ctx_q    <= ctx_d;
      start_q  <= start_d;
      range_q  <= range_d;
      code_q   <= code_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
      dec_q    <= dec_d;
      dec_bv_q <= dec_bv_d;
      if (clear_q) begin
        clr_addr_q <= clr_addr_q + PROB_AW'(1);
        if (clr_addr_q == PROB_AW'(PROB_DEPTH - 1)) clear_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

`ifndef ASSERT_OFF
  a_dec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_q |=> !dec_q) else $error("decode stage held for more than one cycle");
  a_dec_in_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_q |-> (phase_q == PH_BIT && !clear_q)) else $error("decode outside bit phase");
  a_done_no_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && rec_o.finished) |-> rec_o.need == NEED_NONE)
    else $error("finished result still asks for an item");
`endif

endmodule

@@ src/bcj2d_emit.sv @@
// Result emitter: holds transaction results and sends them one byte at a time.
module bcj2d_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bcj2d_pkg::rec_t rec_i,
  output logic            pend_full_o,
  bcj2d_out_if.source     out_o
);
  import bcj2d_pkg::*;

  rec_t       cur_q, pend_q;
  logic       cur_v_q, pend_v_q;
  logic [1:0] idx_q;
  logic       out_fire, is_last, cur_free;

  assign out_fire = out_o.valid && out_o.ready;
  assign is_last  = !cur_q.multi || idx_q == 2'd3;
  assign cur_free = !cur_v_q || (out_fire && is_last);

  assign pend_full_o     = pend_v_q;
  assign out_o.valid      = cur_v_q;
  assign out_o.out_byte   = cur_q.byte_valid ? cur_q.word[{idx_q, 3'b000} +: 8] : 8'h00;
  assign out_o.byte_valid = cur_q.byte_valid;
  assign out_o.need       = cur_q.need;
  assign out_o.status     = cur_q.status;
  assign out_o.finished   = cur_q.finished;
  assign out_o.last       = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      idx_q    <= '0;
    end else if (cur_free) begin
      cur_v_q  <= pend_v_q || push_i;
      pend_v_q <= pend_v_q && push_i;
      idx_q    <= '0;
    end else begin
      pend_v_q <= pend_v_q || push_i;
      if (out_fire) idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_free) cur_q <= pend_v_q ? pend_q : rec_i;
    if (push_i) pend_q <= rec_i;
  end

`ifndef ASSERT_OFF
  a_pend_behind_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> cur_v_q) else $error("skid entry valid while output empty");
  a_single_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_v_q && !cur_q.multi) |-> idx_q == 2'd0) else $error("byte index on single result");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !pend_v_q) else $error("result pushed into full emitter");
`endif

endmodule

@@ src/bcj2_x86_branch_decoder_top.sv @@
// Top level of the BCJ2 x86 branch decoder.
// Throughput: one item per cycle while the emitter has room; input stalls while a branch bit
// is decoded (probability read, then multiply and write-back); an address gives 4 results.
// Reset: control state clears at once; a pass then fills all 258 entries of the probability
// store with 1024, during which no item is taken (configuration writes are).
module bcj2_x86_branch_decoder_top #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bcj2d_in_if.sink                      in_i,
  bcj2d_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcj2d_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bcj2d_pkg::*;

  logic [31:0]        output_size_q;
  logic               push, pend_full;
  rec_t               rec;
  prob_wr_t           prob_wr;
  logic [PROB_AW-1:0] prob_raddr;
  logic [PROB_W-1:0]  prob_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUTPUT_SIZE) ? output_size_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_size_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_SIZE) begin
      output_size_q <= pwdata;
    end
  end

  bcj2d_ram #(
    .WIDTH (PROB_W),
    .DEPTH (PROB_DEPTH)
  ) u_prob (
    .clk_i   (clk_i),
    .we_i    (prob_wr.we),
    .waddr_i (prob_wr.addr),
    .wdata_i (prob_wr.data),
    .raddr_i (prob_raddr),
    .rdata_o (prob_rdata)
  );

  bcj2d_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .output_size_i (output_size_q),
    .in_i          (in_i),
    .pend_full_i   (pend_full),
    .push_o        (push),
    .rec_o         (rec),
    .prob_wr_o     (prob_wr),
    .prob_raddr_o  (prob_raddr),
    .prob_rdata_i  (prob_rdata)
  );

  bcj2d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec_i       (rec),
    .pend_full_o (pend_full),
    .out_o       (out_o)
  );

endmodule
